[hdl/bds_pkg.sv]
// shared types, constants and the candidate select function of the baud divisor search
// no dependencies
package bds_pkg;

   localparam int BAUD_BITS   = 24;
   localparam int CLK_BITS    = 32;
   localparam int OSR_BITS    = 4;
   localparam int DCODE_BITS  = 16;
   localparam int ERR_BITS    = 24;
   localparam int LANES       = 8;
   localparam logic [OSR_BITS-1:0] OSR_TOP = 4'hf;
   localparam logic [CLK_BITS-1:0] CLOCK_RESET = 32'd48000000;
   localparam int DIVIDER_BITS_DEF = 16;

   // first divide: clock / ((osr+1)*baud)
   localparam int Q1_BITS = CLK_BITS;
   localparam int D1_BITS = BAUD_BITS + OSR_BITS;
   // second divide: remainder / ((osr+1)*q)
   localparam int R_BITS  = D1_BITS;
   localparam int D2_BITS = CLK_BITS + OSR_BITS;
   localparam int LANE_LAT = Q1_BITS + 1 + R_BITS;

   typedef struct packed {
      logic                  ok;
      logic [OSR_BITS-1:0]   osr;
      logic [DCODE_BITS-1:0] dcode;
      logic [ERR_BITS-1:0]   err;
   } cand_type;

   // a wins ties, so a must be the earlier (higher oversample) candidate
   function automatic cand_type pick(input cand_type a, input cand_type b);
      if (a.ok && (!b.ok || a.err <= b.err)) begin
         return a;
      end
      return b;
   endfunction

endpackage

[hdl/bds_if.sv]
// channel interfaces for request, response and clock register write
// depends on bds_pkg
interface bds_req_if;
   logic                           valid;
   logic                           ready;
   logic [bds_pkg::BAUD_BITS-1:0]  baud_rate;
   modport source (output valid, baud_rate, input ready);
   modport sink (input valid, baud_rate, output ready);
endinterface

interface bds_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            found;
   logic [bds_pkg::OSR_BITS-1:0]    oversample_code;
   logic [bds_pkg::DCODE_BITS-1:0]  divider_code;
   logic [bds_pkg::ERR_BITS-1:0]    rate_error;
   modport source (output valid, found, oversample_code, divider_code, rate_error,
                   input ready);
   modport sink (input valid, found, oversample_code, divider_code, rate_error,
                 output ready);
endinterface

interface bds_csr_if;
   logic                          valid;
   logic                          ready;
   logic [bds_pkg::CLK_BITS-1:0]  data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

[hdl/bds_div_cell.sv]
// one restoring division step: shifts in a dividend bit, subtracts when it fits
// no package dependency
module bds_div_cell #(
   parameter int N = 32,
   parameter int W = 28
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] d_prev,
   input  logic [W-1:0] rem_prev,
   input  logic [N-1:0] dq_prev,
   output logic [W-1:0] d_ff,
   output logic [W-1:0] rem_ff,
   output logic [N-1:0] dq_ff
);
   logic [W:0]   t;
   logic         ge;
   logic [W-1:0] rem_in;
   logic [N-1:0] dq_in;

   // trial subtract
   always_comb begin
      t      = {rem_prev, dq_prev[N-1]};
      ge     = (t >= {1'b0, d_prev});
      rem_in = ge ? W'(t - {1'b0, d_prev}) : t[W-1:0];
      dq_in  = {dq_prev[N-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff   <= d_prev;
         rem_ff <= rem_in;
         dq_ff  <= dq_in;
      end
   end
endmodule

[hdl/bds_lane.sv]
// one oversample candidate: divider quotient, range check, error quotient
// depends on bds_pkg and bds_div_cell
module bds_lane #(
   parameter int DIVIDER_BITS = bds_pkg::DIVIDER_BITS_DEF,
   parameter logic [bds_pkg::OSR_BITS-1:0] OSR = bds_pkg::OSR_TOP
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic [bds_pkg::BAUD_BITS-1:0] baud,
   input  logic [bds_pkg::CLK_BITS-1:0]  clk_hz,
   output bds_pkg::cand_type             cand
);
   import bds_pkg::*;

   localparam logic [CLK_BITS:0] Limit = (CLK_BITS+1)'((64'd1 << DIVIDER_BITS) - 64'd1);
   localparam logic [OSR_BITS:0] Mult  = {1'b0, OSR} + 5'd1;

   logic [D1_BITS-1:0] d1 [0:Q1_BITS];
   logic [D1_BITS-1:0] r1 [0:Q1_BITS];
   logic [Q1_BITS-1:0] q1 [0:Q1_BITS];
   logic [D2_BITS-1:0] d2 [0:R_BITS];
   logic [D2_BITS-1:0] r2 [0:R_BITS];
   logic [R_BITS-1:0]  q2 [0:R_BITS];
   logic               ok_ff [0:R_BITS];
   logic [DCODE_BITS-1:0] dc_ff [0:R_BITS];
   logic [D2_BITS-1:0] d2_ff;
   logic [R_BITS-1:0]  q2_ff;
   logic               ok_in;
   logic [CLK_BITS:0]  qm1;

   // first divider chain
   assign d1[0] = D1_BITS'(Mult) * D1_BITS'(baud);
   assign r1[0] = '0;
   assign q1[0] = clk_hz;

   for (genvar i = 0; i < Q1_BITS; i++) begin : g_div1
      bds_div_cell #(.N(Q1_BITS), .W(D1_BITS)) u_cell (
         .clock(clock), .en(en),
         .d_prev(d1[i]), .rem_prev(r1[i]), .dq_prev(q1[i]),
         .d_ff(d1[i+1]), .rem_ff(r1[i+1]), .dq_ff(q1[i+1])
      );
   end

   // range check and second divisor
   always_comb begin
      qm1   = {1'b0, q1[Q1_BITS]} - (CLK_BITS+1)'(1);
      ok_in = (q1[Q1_BITS] != '0) && (qm1 <= Limit);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ok_ff[0] <= ok_in;
         dc_ff[0] <= qm1[DCODE_BITS-1:0];
         d2_ff    <= D2_BITS'(Mult) * D2_BITS'(q1[Q1_BITS]);
         q2_ff    <= r1[Q1_BITS];
      end
   end
   assign d2[0] = d2_ff;
   assign q2[0] = q2_ff;
   assign r2[0] = '0;

   // error divider chain
   for (genvar i = 0; i < R_BITS; i++) begin : g_div2
      bds_div_cell #(.N(R_BITS), .W(D2_BITS)) u_cell (
         .clock(clock), .en(en),
         .d_prev(d2[i]), .rem_prev(r2[i]), .dq_prev(q2[i]),
         .d_ff(d2[i+1]), .rem_ff(r2[i+1]), .dq_ff(q2[i+1])
      );
      always_ff @(posedge clock) begin
         if (en) begin
            ok_ff[i+1] <= ok_ff[i];
            dc_ff[i+1] <= dc_ff[i];
         end
      end
   end

   assign cand.ok    = ok_ff[R_BITS];
   assign cand.osr   = OSR;
   assign cand.dcode = dc_ff[R_BITS];
   assign cand.err   = q2[R_BITS][ERR_BITS-1:0];
endmodule

[hdl/baud_divisor_search_unit.sv]
// baud divisor search top: eight oversample lanes of division cells and a select tree
// depends on bds_pkg, bds_if and bds_lane
// a result passes the input, lane cell, pair select and response registers
// throughput: one word per cycle; a stalled response freezes the whole pipeline
// the rate is set by the per-bit division cells, one cell per quotient bit
// reset clears valid flags and loads the clock register with 48000000
module baud_divisor_search_unit #(
   parameter int DIVIDER_BITS = bds_pkg::DIVIDER_BITS_DEF
) (
   input logic         clock,
   input logic         reset,
   bds_req_if.sink     req,
   bds_rsp_if.source   rsp,
   bds_csr_if.sink     csr
);
   import bds_pkg::*;

   logic [CLK_BITS-1:0]  clk_hz_ff;
   logic [BAUD_BITS-1:0] baud_ff;
   logic                 vld_ff  [0:LANE_LAT];
   logic                 zero_ff [0:LANE_LAT];
   cand_type             cand    [0:LANES-1];
   cand_type             pa_ff   [0:3];
   logic                 pa_vld_ff;
   logic                 rsp_vld_ff;
   cand_type             best;
   logic                 en;

   assign en        = !rsp_vld_ff || rsp.ready;
   assign req.ready = en;
   assign csr.ready = 1'b1;

   // clock register
   always_ff @(posedge clock) begin
      if (reset) begin
         clk_hz_ff <= CLOCK_RESET;
      end else if (csr.valid) begin
         clk_hz_ff <= csr.data;
      end
   end

   // input word and control pipeline
   always_ff @(posedge clock) begin
      if (en) begin
         baud_ff    <= req.baud_rate;
         zero_ff[0] <= (req.baud_rate == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req.valid;
      end
   end

   for (genvar i = 0; i < LANE_LAT; i++) begin : g_ctl
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (en) begin
            vld_ff[i+1] <= vld_ff[i];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            zero_ff[i+1] <= zero_ff[i];
         end
      end
   end

   // candidate lanes, oversample 15 down to 8
   for (genvar k = 0; k < LANES; k++) begin : g_lane
      bds_lane #(
         .DIVIDER_BITS(DIVIDER_BITS),
         .OSR(OSR_TOP - OSR_BITS'(k))
      ) u_lane (
         .clock(clock), .en(en), .baud(baud_ff), .clk_hz(clk_hz_ff), .cand(cand[k])
      );
   end

   // first select level, masking an invalid zero baud request
   for (genvar p = 0; p < 4; p++) begin : g_pair
      cand_type ca, cb;
      always_comb begin
         ca    = cand[2*p];
         cb    = cand[2*p+1];
         ca.ok = ca.ok && !zero_ff[LANE_LAT];
         cb.ok = cb.ok && !zero_ff[LANE_LAT];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            pa_ff[p] <= pick(ca, cb);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pa_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         pa_vld_ff  <= vld_ff[LANE_LAT];
         rsp_vld_ff <= pa_vld_ff;
      end
   end

   // final select into the response register
   assign best = pick(pick(pa_ff[0], pa_ff[1]), pick(pa_ff[2], pa_ff[3]));

   always_ff @(posedge clock) begin
      if (en) begin
         rsp.found           <= best.ok;
         rsp.oversample_code <= best.ok ? best.osr : OSR_TOP;
         rsp.divider_code    <= best.ok ? best.dcode : '0;
         rsp.rate_error      <= best.ok ? best.err : '0;
      end
   end

   assign rsp.valid = rsp_vld_ff;
endmodule
